// ----- rtl/rmvn_pkg.sv -----
// Package for the running mean/variance normaliser.
// Shared widths, controller command/status types. No dependencies.
package rmvn_pkg;

    localparam int unsigned OBS_SIZE_DEF = 64;
    localparam logic [30:0] CLIP_RESET   = 31'd327680;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_READ  = 6'b000010,
        ST_MDIV  = 6'b000100,
        ST_M2UPD = 6'b001000,
        ST_VAR   = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the accepted item and read the stores
        logic mdiv_go;   // start the mean division
        logic m2_go;     // compute the new mean and its deviation
        logic var_go;    // write back in update mode, then variance, root, division
        logic finish;    // result moved to the output register
    } cmd_t;

    typedef struct packed {
        logic update;    // item is in update mode
        logic warm;      // count at most one
        logic div_done;  // current iterative step finished
    } stat_t;

endpackage

// ----- rtl/rmvn_ram.sv -----
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
module rmvn_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/rmvn_ctrl.sv -----
// Controller state machine for the normaliser.
// Depends on rmvn_pkg.
module rmvn_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic            out_free,
    input  logic            clear_busy,
    input  rmvn_pkg::stat_t stat,
    output rmvn_pkg::cmd_t  cmd
);
    rmvn_pkg::state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            rmvn_pkg::ST_IDLE: begin
                s_ready = !clear_busy;
                if (s_valid && !clear_busy) begin
                    cmd.capture = 1'b1;
                    state_next  = rmvn_pkg::ST_READ;
                end
            end
            rmvn_pkg::ST_READ: begin
                if (stat.update) begin
                    cmd.mdiv_go = 1'b1;
                    state_next  = rmvn_pkg::ST_MDIV;
                end else begin
                    cmd.var_go = 1'b1;
                    state_next = rmvn_pkg::ST_VAR;
                end
            end
            rmvn_pkg::ST_MDIV: begin
                if (stat.div_done) begin
                    cmd.m2_go  = 1'b1;
                    state_next = rmvn_pkg::ST_M2UPD;
                end
            end
            rmvn_pkg::ST_M2UPD: begin
                cmd.var_go = 1'b1;
                state_next = rmvn_pkg::ST_VAR;
            end
            rmvn_pkg::ST_VAR: begin
                if (stat.div_done) begin
                    state_next = rmvn_pkg::ST_OUT;
                end
            end
            rmvn_pkg::ST_OUT: begin
                if (out_free) begin
                    cmd.finish = 1'b1;
                    state_next = rmvn_pkg::ST_IDLE;
                end
            end
            default: state_next = rmvn_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rmvn_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("controller state not one-hot");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> state_reg == rmvn_pkg::ST_READ)
        else $error("capture did not lead to read");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> state_reg == rmvn_pkg::ST_IDLE)
        else $error("finish did not return to idle");
endmodule

// ----- rtl/rmvn_dp.sv -----
// Datapath: statistics stores, shared serial divider, square root, output register.
// Depends on rmvn_pkg and rmvn_ram.
module rmvn_dp #(
    parameter int unsigned OBS_SIZE = rmvn_pkg::OBS_SIZE_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic signed [31:0] s_sample,
    input  logic               s_mode,
    input  logic [30:0]        clip_limit,
    input  rmvn_pkg::cmd_t     cmd,
    output rmvn_pkg::stat_t    stat,
    output logic               clear_busy,
    output logic               out_free,
    output logic signed [31:0] m_normalized,
    output logic               m_warming_up,
    output logic               m_vector_end,
    output logic               m_valid,
    input  logic               m_ready
);
    localparam int unsigned AW = (OBS_SIZE > 1) ? $clog2(OBS_SIZE) : 1;
    localparam logic [AW-1:0] LAST = AW'(OBS_SIZE - 1);

    typedef enum logic [2:0] {
        PH_NONE = 3'b001, PH_ROOT = 3'b010, PH_QUO = 3'b100
    } phase_t;

    // Clearing pass after reset.
    logic [AW:0] clr_reg;
    assign clear_busy = !clr_reg[AW];

    logic [AW-1:0] pos_reg;
    logic [31:0]   count_reg;
    logic signed [32:0] x_reg;
    logic          upd_reg, last_reg;

    // Stores
    logic          we;
    logic [AW-1:0] waddr;
    logic [31:0]   mean_wd, mean_rd;
    logic [63:0]   m2_wd, m2_rd;

    rmvn_ram #(.WIDTH(32), .DEPTH(OBS_SIZE)) u_mean (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(mean_wd),
        .raddr(pos_reg), .rdata(mean_rd));
    rmvn_ram #(.WIDTH(64), .DEPTH(OBS_SIZE)) u_m2 (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(m2_wd),
        .raddr(pos_reg), .rdata(m2_rd));

    logic signed [31:0] mean_reg;
    logic [63:0]        m2_reg;
    logic signed [32:0] d_reg;

    // Shared restoring divider: 64-bit dividend, 64-bit divisor, one bit a cycle.
    logic [63:0] dvd_reg, quo_reg, dvs_reg;
    logic [64:0] rem_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic [64:0] rem_sh, rem_sub;
    assign rem_sh  = {rem_reg[63:0], dvd_reg[63]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    // Integer square root, two bits of radicand a cycle.
    logic [63:0] sq_v_reg, sq_root_reg, sq_bit_reg;
    logic [64:0] sq_try;
    assign sq_try = {1'b0, sq_root_reg} + {1'b0, sq_bit_reg};

    phase_t phase_reg;
    logic   neg_reg, vq_reg;
    logic signed [32:0] diff_reg;

    logic [31:0] n_eff;
    assign n_eff = (count_reg == 32'd0) ? 32'd1 : count_reg;

    logic [32:0] dmag;
    assign dmag = d_reg[32] ? 33'(-d_reg) : 33'(d_reg);

    // Mean division result and new mean; the M2 product follows in the next cycle, from emag_reg.
    logic signed [32:0] q_s, newmean, e_s;
    logic [32:0] emag, emag_reg;
    logic [65:0] prod;
    logic [64:0] m2sum;
    assign q_s     = d_reg[32] ? -$signed({1'b0, quo_reg[31:0]})
                               : $signed({1'b0, quo_reg[31:0]});
    assign newmean = 33'(mean_reg) + q_s;
    assign e_s     = x_reg - newmean;
    assign emag    = e_s[32] ? 33'(-e_s) : 33'(e_s);
    assign prod    = dmag * emag_reg;
    assign m2sum   = {1'b0, m2_reg} + {1'b0, prod[63:0]};

    assign we      = clear_busy || (cmd.var_go && upd_reg);
    assign waddr   = clear_busy ? clr_reg[AW-1:0] : pos_reg;
    assign mean_wd = clear_busy ? 32'd0 : mean_reg;
    assign m2_wd   = clear_busy ? 64'd0 : (m2sum[64] ? '1 : m2sum[63:0]);

    logic [32:0] dfmag;
    assign dfmag = diff_reg[32] ? 33'(-diff_reg) : 33'(diff_reg);

    logic [63:0] qclip;
    assign qclip = (quo_reg > {33'd0, clip_limit}) ? {33'd0, clip_limit} : quo_reg;

    assign stat.update   = upd_reg;
    assign stat.warm     = count_reg <= 32'd1;
    assign stat.div_done = !busy_reg && vq_reg;

    logic signed [31:0] out_n_reg;
    logic out_w_reg, out_e_reg, out_v_reg;
    assign out_free     = !out_v_reg || m_ready;
    assign m_valid      = out_v_reg;
    assign m_normalized = out_n_reg;
    assign m_warming_up = out_w_reg;
    assign m_vector_end = out_e_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg   <= '0;
            pos_reg   <= '0;
            count_reg <= '0;
            busy_reg  <= 1'b0;
            vq_reg    <= 1'b0;
            phase_reg <= PH_NONE;
            out_v_reg <= 1'b0;
        end else begin
            if (clear_busy) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (m_ready) begin
                out_v_reg <= 1'b0;
            end
            vq_reg <= 1'b0;
            if (cmd.capture) begin
                x_reg    <= 33'(s_sample);
                upd_reg  <= !s_mode;
                last_reg <= pos_reg == LAST;
                if (!s_mode && pos_reg == '0 && count_reg != '1) begin
                    count_reg <= count_reg + 32'd1;
                end
            end
            if (cmd.mdiv_go) begin
                mean_reg  <= mean_rd;
                m2_reg    <= m2_rd;
                d_reg     <= x_reg - 33'($signed(mean_rd));
                dvd_reg   <= '0;
                busy_reg  <= 1'b0;
                phase_reg <= PH_NONE;
                vq_reg    <= 1'b0;
                // Start happens next cycle once d_reg is settled.
                cnt_reg   <= 7'd127;
            end
            if (cmd.m2_go) begin
                mean_reg <= newmean[31:0];
                emag_reg <= emag;
            end
            if (cmd.var_go) begin
                if (!upd_reg) begin
                    mean_reg <= mean_rd;
                    m2_reg   <= m2_rd;
                end else begin
                    m2_reg   <= m2_wd;
                end
                cnt_reg <= 7'd126;
            end
            // Launch sequences after operands are settled.
            if (cnt_reg == 7'd127 && !busy_reg) begin
                dvd_reg  <= {31'd0, dmag};
                dvs_reg  <= {32'd0, n_eff};
                rem_reg  <= '0;
                quo_reg  <= '0;
                cnt_reg  <= 7'd64;
                busy_reg <= 1'b1;
            end else if (cnt_reg == 7'd126 && !busy_reg) begin
                diff_reg <= x_reg - 33'(mean_reg);
                if (stat.warm) begin
                    quo_reg  <= '0;
                    vq_reg   <= 1'b1;
                    cnt_reg  <= 7'd0;
                end else begin
                    dvd_reg   <= m2_reg;
                    dvs_reg   <= {32'd0, count_reg - 32'd1};
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    cnt_reg   <= 7'd64;
                    busy_reg  <= 1'b1;
                    phase_reg <= PH_ROOT;
                end
            end else if (busy_reg) begin
                if (cnt_reg != 7'd0) begin
                    if (!rem_sub[64]) begin
                        rem_reg <= rem_sub;
                        quo_reg <= {quo_reg[62:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[62:0], 1'b0};
                    end
                    dvd_reg <= {dvd_reg[62:0], 1'b0};
                    cnt_reg <= cnt_reg - 7'd1;
                end else begin
                    unique case (phase_reg)
                        PH_NONE: begin
                            busy_reg <= 1'b0;
                            vq_reg   <= 1'b1;
                        end
                        PH_ROOT: begin
                            sq_v_reg    <= quo_reg;
                            sq_root_reg <= '0;
                            sq_bit_reg  <= 64'h4000_0000_0000_0000;
                            phase_reg   <= PH_QUO;
                            cnt_reg     <= 7'd0;
                            rem_reg     <= '1;
                        end
                        PH_QUO: begin
                            if (sq_bit_reg != '0) begin
                                if ({1'b0, sq_v_reg} >= sq_try) begin
                                    sq_v_reg    <= sq_v_reg - sq_try[63:0];
                                    sq_root_reg <= (sq_root_reg >> 1) + sq_bit_reg;
                                end else begin
                                    sq_root_reg <= sq_root_reg >> 1;
                                end
                                sq_bit_reg <= sq_bit_reg >> 2;
                            end else if (rem_reg[64]) begin
                                dvd_reg   <= {15'd0, dfmag, 16'd0};
                                dvs_reg   <= sq_root_reg + 64'd1;
                                rem_reg   <= '0;
                                quo_reg   <= '0;
                                cnt_reg   <= 7'd64;
                                phase_reg <= PH_NONE;
                            end
                        end
                        default: phase_reg <= PH_NONE;
                    endcase
                end
            end
            if (cmd.finish) begin
                out_v_reg <= 1'b1;
                out_n_reg <= diff_reg[32] ? -$signed(qclip[31:0]) : $signed(qclip[31:0]);
                out_w_reg <= stat.warm;
                out_e_reg <= last_reg;
                pos_reg   <= last_reg ? '0 : pos_reg + 1'b1;
                vq_reg    <= 1'b0;
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish && stat.warm |-> qclip == 64'd0)
        else $error("warm-up result not zero");
    assert property (@(posedge aclk) disable iff (!aresetn)
        clear_busy |-> !cmd.var_go)
        else $error("statistics written during clearing pass");
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !cmd.finish)
        else $error("result taken while a unit is busy");
endmodule

// ----- rtl/running_mean_variance_normalizer.sv -----
// Top level of the running mean/variance normaliser.
// Depends on rmvn_pkg, rmvn_ctrl and rmvn_dp.
//
//  channel | ports                                  | direction
//  s_      | s_sample, s_mode, s_valid, s_ready     | item in
//  m_      | m_normalized, m_warming_up, m_vector_end, m_valid, m_ready | item out
//  cfg_    | cfg_clip_limit, cfg_valid, cfg_ready   | register write
//
// An update item runs three bit-serial divisions and a root before the next
// item can be taken. A normalise-only item skips the mean division. Warm-up
// items skip the variance division, the root and the final division; in
// update mode they still run the mean division. After reset a clearing pass
// over the statistics stores runs before the first item.
// The next item is taken once the result has moved to the output register;
// a stalled output holds the following result, and so the input side.
module running_mean_variance_normalizer #(
    parameter int unsigned OBS_SIZE = rmvn_pkg::OBS_SIZE_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic signed [31:0] s_sample,
    input  logic               s_mode,
    input  logic               s_valid,
    output logic               s_ready,
    output logic signed [31:0] m_normalized,
    output logic               m_warming_up,
    output logic               m_vector_end,
    output logic               m_valid,
    input  logic               m_ready,
    input  logic [30:0]        cfg_clip_limit,
    input  logic               cfg_valid,
    output logic               cfg_ready
);
    logic [30:0]     clip_reg;
    rmvn_pkg::cmd_t  cmd;
    rmvn_pkg::stat_t stat;
    logic            out_free, clear_busy;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clip_reg <= rmvn_pkg::CLIP_RESET;
        end else if (cfg_valid) begin
            clip_reg <= cfg_clip_limit;
        end
    end

    rmvn_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .out_free(out_free), .clear_busy(clear_busy), .stat(stat), .cmd(cmd));

    rmvn_dp #(.OBS_SIZE(OBS_SIZE)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .s_sample(s_sample), .s_mode(s_mode),
        .clip_limit(clip_reg), .cmd(cmd), .stat(stat), .clear_busy(clear_busy),
        .out_free(out_free), .m_normalized(m_normalized),
        .m_warming_up(m_warming_up), .m_vector_end(m_vector_end),
        .m_valid(m_valid), .m_ready(m_ready));
endmodule

// ----- sim/running_mean_variance_normalizer_tb.sv -----
// Self-checking testbench for the running mean/variance normaliser.
// Depends on rmvn_pkg and running_mean_variance_normalizer; checks directed items
// against set values, random vectors with idle and stall bursts against a predictor.
module running_mean_variance_normalizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OBS = rmvn_pkg::OBS_SIZE_DEF;
    localparam int ITEMS = 1150;
    localparam int CALM_TAIL = 130;
    localparam int LIMIT = 2000000;
    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_NORM = 1'b1;

    typedef struct {
        logic signed [31:0] norm;
        bit                 warm;
        bit                 last;
    } outcome_t;

    typedef struct {
        logic signed [31:0] sample;
        logic               mode;
        bit                 typed;
        outcome_t           want;
    } stim_row_t;

    logic               aclk;
    logic               aresetn;
    logic signed [31:0] s_sample;
    logic               s_mode;
    logic               s_valid;
    logic               s_ready;
    logic signed [31:0] m_normalized;
    logic               m_warming_up;
    logic               m_vector_end;
    logic               m_valid;
    logic               m_ready;
    logic [30:0]        cfg_clip_limit;
    logic               cfg_valid;
    logic               cfg_ready;

    running_mean_variance_normalizer DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_sample       (s_sample),
        .s_mode         (s_mode),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .m_normalized   (m_normalized),
        .m_warming_up   (m_warming_up),
        .m_vector_end   (m_vector_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .cfg_clip_limit (cfg_clip_limit),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready)
    );

    // Predictor state
    bit [30:0]          clip_now;
    bit [31:0]          vec_count;
    int                 position;
    logic signed [31:0] mean_tbl [OBS];
    bit [63:0]          m2_tbl [OBS];

    outcome_t pending_results [$];
    int       errors;
    int       sent;
    int       checked;
    int       nonzero_seen;
    int       clipped_seen;
    int       clip_writes;
    int       cycles;
    bit       calm;

    function automatic bit [63:0] magnitude(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic bit [63:0] floor_root(input bit [63:0] v);
        bit [63:0] r;
        bit [63:0] c;
        r = 0;
        for (int i = 31; i >= 0; i--) begin
            c = r | (64'd1 << i);
            if (c * c <= v) begin
                r = c;
            end
        end
        return r;
    endfunction

    function automatic outcome_t normalize_step(input logic signed [31:0] smp,
                                                input logic mode);
        outcome_t  o;
        longint    x;
        longint    n;
        longint    prev;
        longint    d;
        longint    e;
        longint    diff;
        bit [63:0] prod;
        bit [63:0] m2;
        bit [63:0] den;
        bit [63:0] qm;
        x = smp;
        if (mode == MODE_UPDATE) begin
            if (position == 0 && vec_count != 32'hFFFF_FFFF) begin
                vec_count++;
            end
            n = (vec_count == 0) ? 1 : longint'({32'd0, vec_count});
            prev = mean_tbl[position];
            d = x - prev;
            mean_tbl[position] = 32'(prev + d / n);
            e = x - longint'(mean_tbl[position]);
            prod = magnitude(d) * magnitude(e);
            m2 = m2_tbl[position];
            m2_tbl[position] = (m2 > ~prod) ? '1 : m2 + prod;
        end
        o.warm = (vec_count <= 1);
        o.norm = 0;
        if (!o.warm) begin
            den = floor_root(m2_tbl[position] / {32'd0, vec_count - 32'd1}) + 1;
            diff = x - longint'(mean_tbl[position]);
            qm = (magnitude(diff) << 16) / den;
            if (qm > {33'd0, clip_now}) begin
                qm = {33'd0, clip_now};
            end
            o.norm = (diff < 0) ? -32'(qm) : 32'(qm);
        end
        o.last = (position == OBS - 1);
        position = (position + 1 >= OBS) ? 0 : position + 1;
        return o;
    endfunction

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("running_mean_variance_normalizer_tb NOT OK");
            $finish;
        end
    end

    // Result side: stall bursts until the calm tail.
    initial begin
        m_ready = 0;
        forever begin
            @(posedge aclk);
            m_ready <= 1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
            if (!calm && aresetn) begin
                m_ready <= 0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        outcome_t w;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected item, normalized %0d", $time, m_normalized);
                errors++;
            end else begin
                w = pending_results.pop_front();
                checked++;
                if (m_normalized != 0) nonzero_seen++;
                if (!w.warm && (w.norm == $signed({1'b0, clip_now}) ||
                                w.norm == -$signed({1'b0, clip_now})))
                    clipped_seen++;
                if (m_normalized !== w.norm) begin
                    $display("%0t: normalized expected %0d actual %0d", $time,
                             w.norm, m_normalized);
                    errors++;
                end
                if (m_warming_up !== w.warm) begin
                    $display("%0t: warming_up expected %0b actual %0b", $time,
                             w.warm, m_warming_up);
                    errors++;
                end
                if (m_vector_end !== w.last) begin
                    $display("%0t: vector_end expected %0b actual %0b", $time,
                             w.last, m_vector_end);
                    errors++;
                end
            end
        end
    end

    task automatic send_item(input logic signed [31:0] smp, input logic mode,
                             input bit typed, input outcome_t want);
        outcome_t p;
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_sample <= smp;
        s_mode <= mode;
        s_valid <= 1;
        do @(posedge aclk); while (!s_ready);
        p = normalize_step(smp, mode);
        pending_results.push_back(typed ? want : p);
        sent++;
        if (sent >= ITEMS - CALM_TAIL) calm = 1;
    endtask

    task automatic drain;
        s_valid <= 0;
        do @(posedge aclk); while (pending_results.size() != 0);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_clip(input bit [30:0] v);
        drain();
        cfg_clip_limit <= v;
        cfg_valid <= 1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        clip_now = v;
        clip_writes++;
    endtask

    function automatic logic signed [31:0] pick_sample(input int pos);
        logic signed [31:0] base;
        base = (pos - 32) * 32'sh0001_0000;
        case ($urandom_range(0, 9))
            0, 1: return $urandom();
            2: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return 0;
                    default: return -1;
                endcase
            end
            3: return base + $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
            default: return base + $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        endcase
    endfunction

    stim_row_t directed [] = '{
        '{32'sh0000_0000,      MODE_NORM,   1, '{0, 1, 0}},
        '{32'sh7FFF_FFFF,      MODE_UPDATE, 1, '{0, 1, 0}},
        '{32'sh8000_0000,      MODE_UPDATE, 1, '{0, 1, 0}},
        '{32'sh0000_0000,      MODE_UPDATE, 1, '{0, 1, 0}},
        '{-32'sd1,             MODE_UPDATE, 1, '{0, 1, 0}},
        '{32'sh0001_0000,      MODE_NORM,   1, '{0, 1, 0}},
        '{32'sh8000_0000,      MODE_NORM,   1, '{0, 1, 0}},
        '{32'sh7FFF_FFFF,      MODE_NORM,   1, '{0, 1, 0}},
        '{32'sh5555_5555,      MODE_UPDATE, 1, '{0, 1, 0}},
        '{32'shAAAA_AAAA,      MODE_UPDATE, 1, '{0, 1, 0}},
        '{32'sh0000_0001,      MODE_UPDATE, 1, '{0, 1, 0}},
        '{-32'sh0005_0000,     MODE_UPDATE, 1, '{0, 1, 0}},
        '{32'sh0005_0000,      MODE_NORM,   1, '{0, 1, 0}},
        '{32'sh1234_5678,      MODE_UPDATE, 1, '{0, 1, 0}},
        '{32'shFEDC_BA98,      MODE_NORM,   1, '{0, 1, 0}},
        '{32'sh0000_8000,      MODE_UPDATE, 1, '{0, 1, 0}}
    };

    initial begin
        bit [30:0] clip_plan [] = '{31'd0, 31'h7FFF_FFFF, 31'd65536, 31'd327680,
                                    31'd1, 31'd196608};
        int        vectors;
        int        len;
        int        flip_at;
        logic      mode;
        outcome_t  none;
        none = '{0, 0, 0};
        aresetn = 0;
        s_valid = 0;
        s_sample = 0;
        s_mode = 0;
        cfg_valid = 0;
        cfg_clip_limit = 0;
        errors = 0;
        sent = 0;
        checked = 0;
        cycles = 0;
        calm = 0;
        clip_now = rmvn_pkg::CLIP_RESET;
        vec_count = 0;
        position = 0;
        foreach (mean_tbl[i]) begin
            mean_tbl[i] = 0;
            m2_tbl[i] = 0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        write_clip(rmvn_pkg::CLIP_RESET);

        foreach (directed[i])
            send_item(directed[i].sample, directed[i].mode, directed[i].typed,
                      directed[i].want);

        // Whole vectors, mostly update mode; now and then the mode flips mid-vector.
        vectors = 0;
        while (sent < ITEMS) begin
            if (vectors % 3 == 2) begin
                if (!calm && vectors / 3 < clip_plan.size())
                    write_clip(clip_plan[vectors / 3]);
                else if (!calm)
                    write_clip(31'($urandom_range(0, 32'h0010_0000)));
            end
            if (vectors == 7) drain();
            len = OBS - position;
            mode = ($urandom_range(0, 4) == 0) ? MODE_NORM : MODE_UPDATE;
            flip_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, OBS - 1) : OBS;
            for (int k = 0; k < len && sent < ITEMS; k++) begin
                if (k == flip_at) mode = ~mode;
                send_item(pick_sample(position), mode, 0, none);
            end
            vectors++;
        end

        s_valid <= 0;
        do @(posedge aclk); while (pending_results.size() != 0);
        repeat (300) @(posedge aclk);
        $display("Sent %0d items in %0d vectors, checked %0d results (%0d non-zero).",
                 sent, vectors, checked, nonzero_seen);
        $display("Clip limit written %0d times; %0d results sat at the clip bound.",
                 clip_writes, clipped_seen);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("running_mean_variance_normalizer_tb OK");
        end else begin
            $display("running_mean_variance_normalizer_tb NOT OK");
        end
        $finish;
    end
endmodule
